>>> rtl/sha256_pkg.sv
// sha256_pkg: constants, types and round functions for the byte-serial sha-256 hasher
// no dependencies
`default_nettype none
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenPos     = 56;
   localparam logic [7:0]  PadMark    = 8'h80;

   typedef enum logic [0:0] {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef logic [31:0] word_type;

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // control from the sequencer to the round unit
   typedef struct packed {
      logic       load;    // copy chain into working vars
      logic       round;   // run one round
      logic       fold;    // add working vars back into chain
      logic       restart; // chain back to initial values
      logic [5:0] rnd;     // round number
   } rnd_ctl_type;

   function automatic word_type ror32(input word_type x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_round.sv
// sha256_round: chain words, working variables, message schedule and the shared round datapath
// depends on sha256_pkg
`default_nettype none
module sha256_round
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rnd_ctl_type ctl,
   input  wire word_type    blk_word,   // block word ctl.rnd during first 16 rounds
   input  wire logic [2:0]  rd_index,
   output word_type         rd_word
);

   word_type chain_ff [8];
   word_type chain_in [8];
   word_type v_ff [8];
   word_type v_in [8];
   word_type w_ff [16];
   word_type w_in [16];

   word_type wt, s0, s1, t1, t2, big0, big1, ch, maj;

   // schedule word and round arithmetic
   always_comb begin
      s0 = ror32(w_ff[1], 7) ^ ror32(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = ror32(w_ff[14], 17) ^ ror32(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wt = (ctl.rnd < 6'd16) ? blk_word : (s1 + w_ff[9] + s0 + w_ff[0]);
      big1 = ror32(v_ff[4], 6) ^ ror32(v_ff[4], 11) ^ ror32(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + RoundK[ctl.rnd] + wt;
      big0 = ror32(v_ff[0], 2) ^ ror32(v_ff[0], 13) ^ ror32(v_ff[0], 22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
   end

   // next state of working vars, window and chain
   always_comb begin
      chain_in = chain_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      if (ctl.load) begin
         v_in = chain_ff;
      end
      if (ctl.round) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wt;
      end
      if (ctl.fold) begin
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + v_ff[i];
      end
      if (ctl.restart) begin
         chain_in = InitHash;
      end
   end

   // chain resets to initial hash; working vars need none
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= InitHash;
      end else begin
         chain_ff <= chain_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign rd_word = chain_ff[rd_index];

endmodule
`default_nettype wire

>>> rtl/sha256_stream_hasher.sv
// sha256_stream_hasher: byte-serial sha-256 top level with block buffer and sequencer
// depends on sha256_pkg and sha256_round
//
//   channel | ports                          | direction
//   request | req_valid/ready, op, data_byte | in
//   result  | rsp_valid/ready, digest_word,  | out
//           | word_index, last_word          |
//
// an absorb request writes one byte; when it fills a block, a load state, 64 rounds
// of the shared round unit and a fold state follow before the next request is taken.
// a finish request feeds padding one byte a cycle, compressing one or two
// blocks, then shows eight result words, one per accepted cycle.
// reset clears the sequencer, counters and chain; the block buffer is not cleared.
// a stalled result holds the hasher; no request is taken until all eight go out.
`default_nettype none
module sha256_stream_hasher
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_FOLD  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff, len_in;     // length latched at finish
   logic        fin_ff, fin_in;     // finishing message
   logic [3:0]  pcnt_ff, pcnt_in;   // padding byte index (0 = mark)
   logic        lenblk_ff, lenblk_in; // current padded block carries the length
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  oidx_ff, oidx_in;

   word_type    buf_mem [16];       // block buffer, big-endian words
   word_type    blk_ff;
   logic [3:0]  rd_addr;
   logic        wr_en;
   logic [7:0]  wr_byte;
   rnd_ctl_type ctl;
   word_type    blk_word, rd_word;
   logic [7:0]  pad_byte;

   // padding byte: mark, zeros, then big-endian length
   always_comb begin
      if (pcnt_ff == 4'd0) begin
         pad_byte = PadMark;
      end else if (lenblk_ff && fill_ff >= 6'(LenPos)) begin
         pad_byte = len_ff[{~fill_ff[2:0], 3'b111} -: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // block word for the first sixteen rounds, read from the buffer in the cycle before its round
   assign rd_addr  = (state_ff == ST_LOAD) ? 4'd0 : (rnd_ff[3:0] + 4'd1);
   assign blk_word = blk_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      len_in    = len_ff;
      fin_in    = fin_ff;
      pcnt_in   = pcnt_ff;
      lenblk_in = lenblk_ff;
      rnd_in    = rnd_ff;
      oidx_in   = oidx_ff;
      wr_en     = 1'b0;
      wr_byte   = req_data_byte;
      ctl       = '0;
      ctl.rnd   = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_ABSORB) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff == 6'd63) state_in = ST_LOAD;
               end else begin
                  len_in    = bits_ff;
                  fin_in    = 1'b1;
                  pcnt_in   = '0;
                  lenblk_in = (fill_ff < 6'(LenPos));
                  state_in  = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wr_en   = 1'b1;
            wr_byte = pad_byte;
            fill_in = fill_ff + 6'd1;
            pcnt_in = 4'd1;
            if (fill_ff == 6'd63) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.load = 1'b1;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (lenblk_ff) begin
               oidx_in  = '0;
               state_in = ST_OUT;
            end else begin
               // mark landed in the length slot: one more block
               lenblk_in = 1'b1;
               state_in  = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  ctl.restart = 1'b1;
                  fin_in   = 1'b0;
                  fill_in  = '0;
                  bits_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         bits_ff   <= '0;
         fin_ff    <= 1'b0;
         pcnt_ff   <= '0;
         lenblk_ff <= 1'b0;
         rnd_ff    <= '0;
         oidx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bits_ff   <= bits_in;
         fin_ff    <= fin_in;
         pcnt_ff   <= pcnt_in;
         lenblk_ff <= lenblk_in;
         rnd_ff    <= rnd_in;
         oidx_ff   <= oidx_in;
      end
      len_ff <= len_in;
   end

   // block buffer: byte writes into big-endian words, registered word read
   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wr_byte;
      blk_ff <= buf_mem[rd_addr];
   end

   sha256_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .blk_word (blk_word),
      .rd_index (oidx_ff),
      .rd_word  (rd_word)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = rd_word;
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);

   // checks
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while results pending");
   a_out_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_word_index == 3'd0) else $error("digest not from word 0");
   a_fold_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FOLD |-> $past(rnd_ff) == 6'd63) else $error("fold early");
   a_out_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fill_ff == 6'd0) else $error("buffer not empty on output");

endmodule
`default_nettype wire
